@@ src/pef_pkg.sv @@
// Shared types, constants and arithmetic helpers of the Prewitt edge filter.
package pef_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int WIDTH_W       = 11;
	localparam int HEIGHT_W      = 12;
	localparam int IN_ROW_W      = HEIGHT_W + 1;
	localparam int MODE_W        = 2;
	localparam int CFG_IW        = 2;
	localparam int CFG_DW        = 12;
	localparam int SQ_STEPS      = 4;
	localparam int SQ_RAD_W      = 16;
	localparam int SQ_REM_W      = 10;

	localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_MODE   = 2'd2;

	localparam logic [MODE_W-1:0] MODE_ROW = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MAG = 2'd2;

	localparam logic REQ_FLUSH = 1'b1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;

	localparam logic [7:0] PIX_MAX = 8'd255;

	typedef logic [7:0] pix_t;

	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	typedef struct packed {
		logic emit;
		logic m_left;
		logic m_right;
		logic m_top;
		logic m_bot;
		logic last;
	} flags_t;

	typedef struct packed {
		logic [SQ_RAD_W-1:0] rad;
		logic [SQ_REM_W-1:0] rem;
		pix_t                root;
	} sqrt_t;

	function automatic pix_t clamp_pix(input logic signed [10:0] v);
		if (v < 0)
			return '0;
		if (v > 11'sd255)
			return PIX_MAX;
		return v[7:0];
	endfunction

	function automatic sqrt_t sqrt_step(input sqrt_t s);
		logic [SQ_REM_W+1:0] t;
		logic [SQ_REM_W+1:0] tr;
		sqrt_t               r;
		t     = {s.rem, s.rad[SQ_RAD_W-1 -: 2]};
		tr    = {2'b00, s.root, 2'b01};
		r.rad = {s.rad[SQ_RAD_W-3:0], 2'b00};
		if (t >= tr) begin
			r.rem  = SQ_REM_W'(t - tr);
			r.root = {s.root[6:0], 1'b1};
		end else begin
			r.rem  = t[SQ_REM_W-1:0];
			r.root = {s.root[6:0], 1'b0};
		end
		return r;
	endfunction

endpackage

@@ src/pef_ifs.sv @@
// Stream and configuration channel interfaces of the Prewitt edge filter.
interface pef_in_if;
	import pef_pkg::*;
	logic valid;
	logic ready;
	logic req_type;
	pix_t pixel;
	modport source(output valid, req_type, pixel, input ready);
	modport sink(input valid, req_type, pixel, output ready);
endinterface

interface pef_out_if;
	import pef_pkg::*;
	logic valid;
	logic ready;
	pix_t edge_res;
	logic last;
	modport source(output valid, edge_res, last, input ready);
	modport sink(input valid, edge_res, last, output ready);
endinterface

interface pef_cfg_if;
	import pef_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ src/pef_line.sv @@
// One line store: a column-addressed delay of one image row, read before write.
module pef_line #(
	parameter int DEPTH = pef_pkg::MAX_WIDTH_DEF,
	parameter int AW    = $clog2(pef_pkg::MAX_WIDTH_DEF)
) (
	input  logic           clk,
	input  logic           en,
	input  logic [AW-1:0]  addr,
	input  pef_pkg::pix_t  wdata,
	output pef_pkg::pix_t  rdata
);
	import pef_pkg::*;

	pix_t mem [DEPTH];
	pix_t rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q    <= mem[addr];
			mem[addr]  <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/pef_col.sv @@
// Window column cell: holds three pixels and takes its neighbour's column on each shift.
module pef_col (
	input  logic          clk,
	input  logic          en,
	input  pef_pkg::col_t d,
	output pef_pkg::col_t q
);
	import pef_pkg::*;

	col_t col_q;

	always_ff @(posedge clk) begin
		if (en)
			col_q <= d;
	end

	assign q = col_q;

endmodule

@@ src/pef_sqrt_cell.sv @@
// Square-root cell: a few digit steps of the integer root, registered.
module pef_sqrt_cell (
	input  logic           clk,
	input  logic           en,
	input  pef_pkg::sqrt_t d,
	output pef_pkg::sqrt_t q
);
	import pef_pkg::*;

	sqrt_t nx;
	sqrt_t st_q;

	always_comb begin
		nx = d;
		for (int i = 0; i < SQ_STEPS; i++)
			nx = sqrt_step(nx);
	end

	always_ff @(posedge clk) begin
		if (en)
			st_q <= nx;
	end

	assign q = st_q;

endmodule

@@ src/prewitt_edge_filter.sv @@
// Prewitt edge filter top level: position counters, line stores, window cells, gradient pipe.
// Throughput: one item per cycle when not stalled; results trail inputs by W+1 items.
// A result is valid once the transaction that completes its window has passed stages s1 to s7.
// The line stores are one read-before-write port each, accessed once per item.
// Reset clears counters, pipeline valids and sets width 640, height 480, combined mode.
// Line stores are not cleared; every entry is written before use in an image.
module prewitt_edge_filter #(
	parameter int MAX_WIDTH = pef_pkg::MAX_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	pef_in_if.sink      pixels,
	pef_out_if.source   results,
	pef_cfg_if.sink     cfg
);
	import pef_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	function automatic logic [CW-1:0] wlast_of(input logic [WIDTH_W-1:0] v);
		if (v == '0)
			return '0;
		if (int'(v) > MAX_WIDTH)
			return CW'(MAX_WIDTH - 1);
		return CW'(v - 1'b1);
	endfunction

	function automatic logic [HEIGHT_W-1:0] hlast_of(input logic [HEIGHT_W-1:0] v);
		if (v == '0)
			return '0;
		return v - 1'b1;
	endfunction

	function automatic pix_t pz(input logic m, input pix_t v);
		return m ? '0 : v;
	endfunction

	logic [CW-1:0]       wlast_q;
	logic [HEIGHT_W-1:0] hlast_q;
	logic [MODE_W-1:0]   mode_q;
	logic [CW-1:0]       in_col_q;
	logic [IN_ROW_W-1:0] in_row_q;
	logic [CW-1:0]       out_col_q;
	logic [HEIGHT_W-1:0] out_row_q;

	logic cfg_wr, acc, go, in_img, emit, is_last;
	flags_t fl;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;

	pix_t          pixel_s1, pixel_s2, rd1, rd2, rd1_s2;
	logic [CW-1:0] col_s1;
	flags_t        fl_s1, fl_s2, fl_s3;
	col_t          col_in, c0, c1, c2;

	pix_t              gr_s4, gc_s4, gr_n, gc_n;
	logic              last_s4, last_s5, last_s6, last_s7;
	logic [16:0]       sum_s5;
	pix_t              val_s5, val_s6, val_s7;
	logic              sq_s5, sq_s6, sq_s7, sat_s6, sat_s7;
	logic [MODE_W-1:0] mode_s4;
	sqrt_t             sq_in, sq_mid, sq_out;

	pix_t lt, mt, rt, lm, rm, lb, mb, rb;
	logic [9:0] sum_top, sum_bot, sum_lft, sum_rgt;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	assign ld7 = !v_s7 || results.ready;
	assign ld6 = !v_s6 || ld7;
	assign ld5 = !v_s5 || ld6;
	assign ld4 = !v_s4 || ld5;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;
	assign pixels.ready = ld1 && !cfg.valid;

	assign acc     = pixels.valid && pixels.ready;
	assign in_img  = in_row_q <= {1'b0, hlast_q};
	assign go      = acc && !(pixels.req_type == REQ_FLUSH && in_img);
	assign emit    = (in_row_q >= IN_ROW_W'(2)) || (in_row_q == IN_ROW_W'(1) && in_col_q != '0);
	assign is_last = emit && out_col_q == wlast_q && out_row_q == hlast_q;

	assign fl = '{
		emit:    emit,
		m_left:  out_col_q == '0,
		m_right: out_col_q == wlast_q,
		m_top:   out_row_q == '0,
		m_bot:   out_row_q == hlast_q,
		last:    is_last
	};

	// position counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q   <= wlast_of(WIDTH_RST);
			hlast_q   <= hlast_of(HEIGHT_RST);
			mode_q    <= MODE_MAG;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				CFG_WIDTH:  wlast_q <= wlast_of(cfg.data[WIDTH_W-1:0]);
				CFG_HEIGHT: hlast_q <= hlast_of(cfg.data[HEIGHT_W-1:0]);
				CFG_MODE:   mode_q  <= cfg.data[MODE_W-1:0];
				default: ;
			endcase
			if (cfg.index == CFG_WIDTH || cfg.index == CFG_HEIGHT || cfg.index == CFG_MODE) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end
		end else if (go) begin
			if (is_last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_q == wlast_q) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (emit) begin
					if (out_col_q == wlast_q) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= go;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2 && fl_s2.emit;
			if (ld4) v_s4 <= v_s3;
			if (ld5) v_s5 <= v_s4;
			if (ld6) v_s6 <= v_s5;
			if (ld7) v_s7 <= v_s6;
		end
	end

	pef_line #(.DEPTH(MAX_WIDTH), .AW(CW)) u_line1 (
		.clk   (clk),
		.en    (go),
		.addr  (in_col_q),
		.wdata (pixels.pixel),
		.rdata (rd1)
	);

	pef_line #(.DEPTH(MAX_WIDTH), .AW(CW)) u_line2 (
		.clk   (clk),
		.en    (v_s1 && ld2),
		.addr  (col_s1),
		.wdata (rd1),
		.rdata (rd2)
	);

	assign col_in = '{top: rd2, mid: rd1_s2, bot: pixel_s2};

	pef_col u_col2 (.clk(clk), .en(v_s2 && ld3), .d(col_in), .q(c2));
	pef_col u_col1 (.clk(clk), .en(v_s2 && ld3), .d(c2),     .q(c1));
	pef_col u_col0 (.clk(clk), .en(v_s2 && ld3), .d(c1),     .q(c0));

	always_comb begin
		lt = pz(fl_s3.m_left  || fl_s3.m_top, c0.top);
		lm = pz(fl_s3.m_left,                 c0.mid);
		lb = pz(fl_s3.m_left  || fl_s3.m_bot, c0.bot);
		mt = pz(fl_s3.m_top,                  c1.top);
		mb = pz(fl_s3.m_bot,                  c1.bot);
		rt = pz(fl_s3.m_right || fl_s3.m_top, c2.top);
		rm = pz(fl_s3.m_right,                c2.mid);
		rb = pz(fl_s3.m_right || fl_s3.m_bot, c2.bot);
		sum_top = 10'(lt) + 10'(mt) + 10'(rt);
		sum_bot = 10'(lb) + 10'(mb) + 10'(rb);
		sum_lft = 10'(lt) + 10'(lm) + 10'(lb);
		sum_rgt = 10'(rt) + 10'(rm) + 10'(rb);
		gr_n = clamp_pix(signed'({1'b0, sum_bot}) - signed'({1'b0, sum_top}));
		gc_n = clamp_pix(signed'({1'b0, sum_rgt}) - signed'({1'b0, sum_lft}));
	end

	assign sq_in = '{rad: sum_s5[15:0], rem: '0, root: '0};

	pef_sqrt_cell u_sq0 (.clk(clk), .en(ld6), .d(sq_in),  .q(sq_mid));
	pef_sqrt_cell u_sq1 (.clk(clk), .en(ld7), .d(sq_mid), .q(sq_out));

	// pipeline payload
	always_ff @(posedge clk) begin
		if (ld1) begin
			pixel_s1 <= pixels.pixel;
			col_s1   <= in_col_q;
			fl_s1    <= fl;
		end
		if (ld2) begin
			pixel_s2 <= pixel_s1;
			rd1_s2   <= rd1;
			fl_s2    <= fl_s1;
		end
		if (ld3)
			fl_s3 <= fl_s2;
		if (ld4) begin
			gr_s4   <= gr_n;
			gc_s4   <= gc_n;
			mode_s4 <= mode_q;
			last_s4 <= fl_s3.last;
		end
		if (ld5) begin
			sum_s5  <= 17'(16'(gr_s4) * 16'(gr_s4)) + 17'(16'(gc_s4) * 16'(gc_s4));
			last_s5 <= last_s4;
			unique case (mode_s4)
				MODE_ROW: begin
					val_s5 <= gr_s4;
					sq_s5  <= 1'b0;
				end
				MODE_COL: begin
					val_s5 <= gc_s4;
					sq_s5  <= 1'b0;
				end
				default: begin
					val_s5 <= gr_s4;
					sq_s5  <= 1'b1;
				end
			endcase
		end
		if (ld6) begin
			val_s6  <= val_s5;
			sq_s6   <= sq_s5;
			sat_s6  <= sum_s5[16];
			last_s6 <= last_s5;
		end
		if (ld7) begin
			val_s7  <= val_s6;
			sq_s7   <= sq_s6;
			sat_s7  <= sat_s6;
			last_s7 <= last_s6;
		end
	end

	assign results.valid    = v_s7;
	assign results.edge_res = sq_s7 ? (sat_s7 ? PIX_MAX : sq_out.root) : val_s7;
	assign results.last     = last_s7;

	assert property (@(posedge clk) disable iff (!arst_n)
		go && is_last && !cfg_wr |=> in_col_q == '0 && in_row_q == '0 && out_col_q == '0
			&& out_row_q == '0)
		else $error("position counters not restarted after the final pixel");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_col_q <= wlast_q && out_col_q <= wlast_q)
		else $error("column counter beyond image width");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= IN_ROW_W'(hlast_q) + IN_ROW_W'(2))
		else $error("input row beyond the drain of the image");

	assert property (@(posedge clk) disable iff (!arst_n)
		go && !emit |-> !is_last)
		else $error("final result flagged on an item that completes no window");

endmodule
